[sv/assert_macros.svh]
// Assertion macros used by the top-level RTL file of the vertex transform block.
// Define ASSERT_OFF to compile every assertion away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// The property must hold at every rising clock edge outside reset.
`define VMT_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// The expression must never be true at a rising clock edge outside reset.
`define VMT_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define VMT_ASSERT(lbl, clk, rst_n, prop, msg)
`define VMT_ASSERT_NEVER(lbl, clk, rst_n, expr, msg)

`endif

`endif

[sv/vmt_pkg.sv]
package vmt_pkg;

  // Component and coefficient formats.
  localparam int DataW         = 32;   // signed Q16.16 vertex component
  localparam int CoeffW        = 16;   // signed Q4.12 matrix coefficient
  localparam int CoeffFracBits = 12;
  localparam int NumComp       = 4;
  localparam int RowW          = NumComp * CoeffW;

  // Exact widths of the arithmetic.
  localparam int ProdW = DataW + CoeffW;     // one product
  localparam int PairW = ProdW + 1;          // sum of two products
  localparam int SumW  = ProdW + 2;          // sum of four products
  localparam int ShW   = SumW - CoeffFracBits;

  // Pipeline stages.
  localparam int NumStages = 4;
  localparam int StgMul    = 0;
  localparam int StgPair   = 1;
  localparam int StgSum    = 2;
  localparam int StgOut    = 3;

  localparam logic signed [DataW-1:0] DataMax = {1'b0, {(DataW-1){1'b1}}};
  localparam logic signed [DataW-1:0] DataMin = {1'b1, {(DataW-1){1'b0}}};

  // Configuration register indexes.
  localparam int CfgIdxW = 2;
  typedef enum logic [CfgIdxW-1:0] {
    CfgRow0 = 2'd0,
    CfgRow1 = 2'd1,
    CfgRow2 = 2'd2,
    CfgRow3 = 2'd3
  } cfg_reg_e;

  typedef logic [NumComp-1:0][DataW-1:0] comp_vec_t;

  // Per-stage load enables handed from the pipeline control to each row.
  typedef struct packed {
    logic [NumStages-1:0] load;
  } pipe_ctrl_t;

endpackage

[sv/vmt_stream_if.sv]
// Input vertex channel.
interface vmt_vtx_if;
  logic                              valid;
  logic                              ready;
  logic signed [vmt_pkg::DataW-1:0]  vx;
  logic signed [vmt_pkg::DataW-1:0]  vy;
  logic signed [vmt_pkg::DataW-1:0]  vz;
  logic signed [vmt_pkg::DataW-1:0]  vw;

  modport source (output valid, output vx, output vy, output vz, output vw, input ready);
  modport sink   (input valid, input vx, input vy, input vz, input vw, output ready);
endinterface

// Transformed vertex channel.
interface vmt_res_if;
  logic                              valid;
  logic                              ready;
  logic signed [vmt_pkg::DataW-1:0]  tx;
  logic signed [vmt_pkg::DataW-1:0]  ty;
  logic signed [vmt_pkg::DataW-1:0]  tz;
  logic signed [vmt_pkg::DataW-1:0]  tw;
  logic                              saturated;

  modport source (output valid, output tx, output ty, output tz, output tw,
                  output saturated, input ready);
  modport sink   (input valid, input tx, input ty, input tz, input tw,
                  input saturated, output ready);
endinterface

[sv/vmt_row_dp.sv]
// Dot product of one matrix row with the vertex, in four register stages.
module vmt_row_dp (
  input  logic                                clk_i,
  input  vmt_pkg::pipe_ctrl_t                 ctrl_i,
  input  logic [vmt_pkg::RowW-1:0]            coeffs_i,
  input  vmt_pkg::comp_vec_t                  vtx_i,
  output logic signed [vmt_pkg::DataW-1:0]    res_o,
  output logic                                sat_o
);

  logic signed [vmt_pkg::ProdW-1:0] prod_d [vmt_pkg::NumComp];
  logic signed [vmt_pkg::ProdW-1:0] prod_q [vmt_pkg::NumComp];
  logic signed [vmt_pkg::PairW-1:0] pair_q [2];
  logic signed [vmt_pkg::SumW-1:0]  sum_q;
  logic signed [vmt_pkg::ShW-1:0]   shifted;
  logic [vmt_pkg::ShW-vmt_pkg::DataW:0] upper;
  logic signed [vmt_pkg::DataW-1:0] res_d, res_q;
  logic                             sat_d, sat_q;

  // Stage one: one 16 by 32 bit product per column.
  always_comb begin
    for (int c = 0; c < vmt_pkg::NumComp; c++) begin
      prod_d[c] = vmt_pkg::ProdW'(signed'(coeffs_i[c*vmt_pkg::CoeffW +: vmt_pkg::CoeffW]))
                * vmt_pkg::ProdW'(signed'(vtx_i[c]));
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load[vmt_pkg::StgMul]) begin
      for (int c = 0; c < vmt_pkg::NumComp; c++) begin
        prod_q[c] <= prod_d[c];
      end
    end
  end

  // Stage two: pairwise sums.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load[vmt_pkg::StgPair]) begin
      pair_q[0] <= vmt_pkg::PairW'(prod_q[0]) + vmt_pkg::PairW'(prod_q[1]);
      pair_q[1] <= vmt_pkg::PairW'(prod_q[2]) + vmt_pkg::PairW'(prod_q[3]);
    end
  end

  // Stage three: the full sum, which cannot overflow at this width.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load[vmt_pkg::StgSum]) begin
      sum_q <= vmt_pkg::SumW'(pair_q[0]) + vmt_pkg::SumW'(pair_q[1]);
    end
  end

  // Stage four: floor shift and clamp to 32 bits. The value fits when all
  // bits from the sign of the narrow result upwards agree.
  always_comb begin
    shifted = vmt_pkg::ShW'(sum_q >>> vmt_pkg::CoeffFracBits);
    upper   = shifted[vmt_pkg::ShW-1:vmt_pkg::DataW-1];
    if ((&upper) || !(|upper)) begin
      res_d = shifted[vmt_pkg::DataW-1:0];
      sat_d = 1'b0;
    end else if (shifted[vmt_pkg::ShW-1]) begin
      res_d = vmt_pkg::DataMin;
      sat_d = 1'b1;
    end else begin
      res_d = vmt_pkg::DataMax;
      sat_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load[vmt_pkg::StgOut]) begin
      res_q <= res_d;
      sat_q <= sat_d;
    end
  end

  assign res_o = res_q;
  assign sat_o = sat_q;

endmodule

[sv/vertex_matrix_transform_unit.sv]
// Channel   Direction  Handshake      Payload
// vtx_i     in         valid/ready    vx, vy, vz, vw      (signed Q16.16)
// res_o     out        valid/ready    tx, ty, tz, tw      (signed Q16.16), saturated
// cfg       in         cfg_we_i       cfg_idx_i, cfg_wdata_i (one matrix row)
//
// One vertex is taken per clock unless a stalled output has backed up every stage.
// The four register stages are the multipliers, the pairwise adders, the final adder and
// the shift-and-clamp output register, each with its own valid bit.
// A stalled output holds its result; stages behind it keep filling until full, so input
// ready drops only when all four stages hold a vertex.
// Reset clears the valid bits and the matrix rows to zero.
`include "assert_macros.svh"

module vertex_matrix_transform_unit (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  vmt_vtx_if.sink                               vtx_i,
  vmt_res_if.source                             res_o,
  input  logic                                  cfg_we_i,
  input  logic [vmt_pkg::CfgIdxW-1:0]           cfg_idx_i,
  input  logic [vmt_pkg::RowW-1:0]              cfg_wdata_i
);

  // Matrix rows, one per output component.
  logic [vmt_pkg::RowW-1:0] row_d [vmt_pkg::NumComp];
  logic [vmt_pkg::RowW-1:0] row_q [vmt_pkg::NumComp];

  always_comb begin
    for (int r = 0; r < vmt_pkg::NumComp; r++) begin
      row_d[r] = row_q[r];
    end
    if (cfg_we_i) begin
      case (vmt_pkg::cfg_reg_e'(cfg_idx_i))
        vmt_pkg::CfgRow0: row_d[0] = cfg_wdata_i;
        vmt_pkg::CfgRow1: row_d[1] = cfg_wdata_i;
        vmt_pkg::CfgRow2: row_d[2] = cfg_wdata_i;
        vmt_pkg::CfgRow3: row_d[3] = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < vmt_pkg::NumComp; r++) begin
        row_q[r] <= '0;
      end
    end else begin
      for (int r = 0; r < vmt_pkg::NumComp; r++) begin
        row_q[r] <= row_d[r];
      end
    end
  end

  // Pipeline control. A stage can take a new vertex when it is empty or when its
  // own content moves on in the same cycle, so bubbles are squeezed out.
  logic [vmt_pkg::NumStages:0]   stg_rdy;
  logic [vmt_pkg::NumStages-1:0] stg_prev_vld;
  logic [vmt_pkg::NumStages-1:0] vld_d, vld_q;
  vmt_pkg::pipe_ctrl_t           ctrl;

  always_comb begin
    stg_rdy[vmt_pkg::NumStages] = res_o.ready;
    for (int k = vmt_pkg::NumStages - 1; k >= 0; k--) begin
      stg_rdy[k] = !vld_q[k] || stg_rdy[k+1];
    end
    stg_prev_vld[0] = vtx_i.valid;
    for (int k = 1; k < vmt_pkg::NumStages; k++) begin
      stg_prev_vld[k] = vld_q[k-1];
    end
    for (int k = 0; k < vmt_pkg::NumStages; k++) begin
      ctrl.load[k] = stg_rdy[k] && stg_prev_vld[k];
      vld_d[k]     = stg_rdy[k] ? stg_prev_vld[k] : vld_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign vtx_i.ready = stg_rdy[0];

  // The same vertex feeds all four row units.
  vmt_pkg::comp_vec_t vtx_vec;
  assign vtx_vec[0] = vtx_i.vx;
  assign vtx_vec[1] = vtx_i.vy;
  assign vtx_vec[2] = vtx_i.vz;
  assign vtx_vec[3] = vtx_i.vw;

  logic signed [vmt_pkg::DataW-1:0] row_res [vmt_pkg::NumComp];
  logic [vmt_pkg::NumComp-1:0]      row_sat;

  for (genvar r = 0; r < vmt_pkg::NumComp; r++) begin : g_row
    vmt_row_dp u_row (
      .clk_i    (clk_i),
      .ctrl_i   (ctrl),
      .coeffs_i (row_q[r]),
      .vtx_i    (vtx_vec),
      .res_o    (row_res[r]),
      .sat_o    (row_sat[r])
    );
  end

  // The row units' last stage is the output register.
  assign res_o.valid     = vld_q[vmt_pkg::StgOut];
  assign res_o.tx        = row_res[0];
  assign res_o.ty        = row_res[1];
  assign res_o.tz        = row_res[2];
  assign res_o.tw        = row_res[3];
  assign res_o.saturated = |row_sat;

  // A vertex transfer always lands in the multiplier stage.
  `VMT_ASSERT(a_accept_fills_first, clk_i, rst_ni,
              vtx_i.valid && vtx_i.ready |=> vld_q[vmt_pkg::StgMul],
              "accepted vertex did not enter the first stage")

  // Input back-pressure only when every stage is occupied.
  `VMT_ASSERT(a_stall_only_when_full, clk_i, rst_ni,
              !vtx_i.ready |-> (&vld_q),
              "input stalled while the pipeline had a free stage")

  // A held result must not vanish from the output register.
  `VMT_ASSERT_NEVER(a_no_lost_result, clk_i, rst_ni,
                    $past(vld_q[vmt_pkg::StgOut]) && !$past(res_o.ready)
                    && !vld_q[vmt_pkg::StgOut],
                    "stalled result was dropped")

  // The flag is raised only if some component sits at a clamp limit.
  `VMT_ASSERT(a_sat_at_limit, clk_i, rst_ni,
              res_o.valid && res_o.saturated |->
              (res_o.tx == vmt_pkg::DataMax || res_o.tx == vmt_pkg::DataMin ||
               res_o.ty == vmt_pkg::DataMax || res_o.ty == vmt_pkg::DataMin ||
               res_o.tz == vmt_pkg::DataMax || res_o.tz == vmt_pkg::DataMin ||
               res_o.tw == vmt_pkg::DataMax || res_o.tw == vmt_pkg::DataMin),
              "saturation flag without a clamped component")

endmodule
